### sv/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg: shared definitions for the length-prefixed packet deframer
// Result kinds, header byte positions, packet size limits and the result
// record that travels from the parser through the queue to the output stage.
// ----------------------------------------------------------------------------
package lppd_pkg;

  typedef enum logic [1:0] {
    KIND_POSITION  = 2'd0,
    KIND_BAD_SIZE  = 2'd1,
    KIND_TOO_SHORT = 2'd2,
    KIND_UNKNOWN   = 2'd3
  } kind_t;

  localparam logic [15:0] MIN_PACKET_BYTES       = 16'd4;
  localparam logic [15:0] POSITION_PACKET_BYTES  = 16'd24;
  localparam logic [15:0] MAX_PACKET_BYTES_RESET = 16'd120;

  localparam logic [15:0] IDX_LEN_LO   = 16'd0;
  localparam logic [15:0] IDX_LEN_HI   = 16'd1;
  localparam logic [15:0] IDX_TYPE_LO  = 16'd2;
  localparam logic [15:0] IDX_TYPE_HI  = 16'd3;
  localparam logic [15:0] IDX_TIME_END = 16'd12;
  localparam logic [15:0] IDX_RA_END   = 16'd16;
  localparam logic [15:0] IDX_DEC_END  = 16'd20;

  localparam logic [15:0] TYPE_POSITION = 16'd0;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] server_time;
    logic [31:0] right_ascension;
    logic [31:0] declination;
    logic [31:0] mount_status;
    logic [15:0] packet_length;
    logic [15:0] packet_type;
  } rec_t;

endpackage

### sv/lppd_parser.sv
// ----------------------------------------------------------------------------
// lppd_parser: byte-level packet parser
// Tracks the position within the current packet, collects the header and the
// payload fields, and classifies each packet end into a result record.
// ----------------------------------------------------------------------------
module lppd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        data_byte,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output logic              rec_valid,
  output lppd_pkg::rec_t    rec
);

  logic [15:0] max_bytes_r;
  logic [15:0] byte_index_r, byte_index_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] type_r, type_nxt;
  logic [63:0] time_r, time_nxt;
  logic [31:0] ra_r, ra_nxt;
  logic [31:0] dec_r, dec_nxt;
  logic [31:0] status_r, status_nxt;
  logic [16:0] index_plus_one;

  assign index_plus_one = {1'b0, byte_index_r} + 17'd1;

  always_comb begin
    byte_index_nxt = byte_index_r;
    length_nxt     = length_r;
    type_nxt       = type_r;
    time_nxt       = time_r;
    ra_nxt         = ra_r;
    dec_nxt        = dec_r;
    status_nxt     = status_r;
    rec_valid      = 1'b0;
    rec.kind       = lppd_pkg::KIND_POSITION;
    if (byte_valid) begin
      if (byte_index_r == lppd_pkg::IDX_LEN_LO) begin
        length_nxt     = {8'h00, data_byte};
        byte_index_nxt = lppd_pkg::IDX_LEN_HI;
      end else if (byte_index_r == lppd_pkg::IDX_LEN_HI) begin
        length_nxt = {data_byte, length_r[7:0]};
        if (length_nxt < lppd_pkg::MIN_PACKET_BYTES || length_nxt > max_bytes_r) begin
          rec_valid      = 1'b1;
          rec.kind       = lppd_pkg::KIND_BAD_SIZE;
          byte_index_nxt = lppd_pkg::IDX_LEN_LO;
        end else begin
          byte_index_nxt = lppd_pkg::IDX_TYPE_LO;
        end
      end else begin
        if (byte_index_r == lppd_pkg::IDX_TYPE_LO) begin
          type_nxt = {8'h00, data_byte};
        end else if (byte_index_r == lppd_pkg::IDX_TYPE_HI) begin
          type_nxt = {data_byte, type_r[7:0]};
        end else if (byte_index_r < lppd_pkg::IDX_TIME_END) begin
          time_nxt = {data_byte, time_r[63:8]};
        end else if (byte_index_r < lppd_pkg::IDX_RA_END) begin
          ra_nxt = {data_byte, ra_r[31:8]};
        end else if (byte_index_r < lppd_pkg::IDX_DEC_END) begin
          dec_nxt = {data_byte, dec_r[31:8]};
        end else if (byte_index_r < lppd_pkg::POSITION_PACKET_BYTES) begin
          status_nxt = {data_byte, status_r[31:8]};
        end
        if (index_plus_one >= {1'b0, length_r}) begin
          rec_valid      = 1'b1;
          byte_index_nxt = lppd_pkg::IDX_LEN_LO;
          if (type_nxt != lppd_pkg::TYPE_POSITION) begin
            rec.kind = lppd_pkg::KIND_UNKNOWN;
          end else if (length_r < lppd_pkg::POSITION_PACKET_BYTES) begin
            rec.kind = lppd_pkg::KIND_TOO_SHORT;
          end else begin
            rec.kind = lppd_pkg::KIND_POSITION;
          end
        end else begin
          byte_index_nxt = index_plus_one[15:0];
        end
      end
    end
    rec.server_time     = time_nxt;
    rec.right_ascension = ra_nxt;
    rec.declination     = dec_nxt;
    rec.mount_status    = status_nxt;
    rec.packet_length   = length_nxt;
    rec.packet_type     = (rec.kind == lppd_pkg::KIND_BAD_SIZE) ? 16'd0 : type_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r  <= lppd_pkg::MAX_PACKET_BYTES_RESET;
      byte_index_r <= lppd_pkg::IDX_LEN_LO;
    end else begin
      if (cfg_wr_en) begin
        max_bytes_r <= cfg_wr_data;
      end
      byte_index_r <= byte_index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    length_r <= length_nxt;
    type_r   <= type_nxt;
    time_r   <= time_nxt;
    ra_r     <= ra_nxt;
    dec_r    <= dec_nxt;
    status_r <= status_nxt;
  end

  // Past the length bytes, the position always stays inside a valid packet.
  a_index_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_index_r >= lppd_pkg::IDX_TYPE_LO) |->
      (byte_index_r < length_r && length_r >= lppd_pkg::MIN_PACKET_BYTES))
    else $error("byte index outside of the current packet");

  a_bad_size_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_valid && rec.kind == lppd_pkg::KIND_BAD_SIZE) |=>
      (byte_index_r == lppd_pkg::IDX_LEN_LO))
    else $error("bad size did not return to awaiting a length");

endmodule

### sv/lppd_queue.sv
// ----------------------------------------------------------------------------
// lppd_queue: result record queue
// Small first-in first-out buffer that decouples the parser from the output
// stage; the head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module lppd_queue #(
  parameter int DEPTH = lppd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lppd_pkg::rec_t push_rec,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output lppd_pkg::rec_t head_rec
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

  lppd_pkg::rec_t store [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == COUNT_MAX);
  assign empty    = (count_r == '0);
  assign head_rec = store[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

### sv/lppd_out_stage.sv
// ----------------------------------------------------------------------------
// lppd_out_stage: result output register
// Pulls records from the queue into the output register and clears the
// payload fields of every result that is not a position record.
// ----------------------------------------------------------------------------
module lppd_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lppd_pkg::rec_t q_rec,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output lppd_pkg::rec_t out_rec
);

  logic           valid_r, valid_nxt;
  lppd_pkg::rec_t rec_r, rec_nxt;

  assign q_pop     = !q_empty && (!valid_r || out_pop);
  assign out_empty = !valid_r;
  assign out_rec   = rec_r;

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
    rec_nxt = q_rec;
    if (q_rec.kind != lppd_pkg::KIND_POSITION) begin
      rec_nxt.server_time     = '0;
      rec_nxt.right_ascension = '0;
      rec_nxt.declination     = '0;
      rec_nxt.mount_status    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= rec_nxt;
    end
  end

  a_payload_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && rec_r.kind != lppd_pkg::KIND_POSITION) |->
      (rec_r.server_time == '0 && rec_r.right_ascension == '0 &&
       rec_r.declination == '0 && rec_r.mount_status == '0))
    else $error("payload not cleared on a non-position result");

endmodule

### sv/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer: top level of the packet deframer
// Accepts one byte per cycle while the result queue has room.
// Results pass from the parser through the queue into the output register.
// The parser handles one byte per cycle; the queue and output stage move one
// result per cycle while out_pop is high, so bytes are taken while earlier
// results wait. Synchronous reset clears the parser position, the queue and
// the output valid flag and sets the size limit to 120 bytes.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer #(
  parameter int QUEUE_DEPTH = lppd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_kind,
  output logic signed [63:0] out_server_time,
  output logic [31:0]        out_right_ascension,
  output logic signed [31:0] out_declination,
  output logic signed [31:0] out_mount_status,
  output logic [15:0]        out_packet_length,
  output logic [15:0]        out_packet_type,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  logic           in_accept;
  logic           rec_valid;
  lppd_pkg::rec_t rec;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  lppd_pkg::rec_t q_rec;
  lppd_pkg::rec_t out_rec;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  lppd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_accept),
    .data_byte   (in_data_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  lppd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_valid),
    .push_rec (rec),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_rec (q_rec)
  );

  lppd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_rec   (out_rec)
  );

  assign out_kind            = out_rec.kind;
  assign out_server_time     = $signed(out_rec.server_time);
  assign out_right_ascension = out_rec.right_ascension;
  assign out_declination     = $signed(out_rec.declination);
  assign out_mount_status    = $signed(out_rec.mount_status);
  assign out_packet_length   = out_rec.packet_length;
  assign out_packet_type     = out_rec.packet_type;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the length-prefixed packet deframer
// A byte stream of position packets, short and unknown-type packets, bad
// lengths and line noise is pushed into the deframer under several size
// limits and flow-control patterns. A predictor tracks the packet parser and
// every popped record is compared field by field with the one it predicts.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [15:0] limit;
    logic [15:0] idx;
    logic [15:0] len;
    logic [15:0] ptype;
    logic [63:0] tm;
    logic [31:0] ra;
    logic [31:0] dec;
    logic [31:0] st;
  } parse_state_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [1:0]         out_kind;
  logic signed [63:0] out_server_time;
  logic [31:0]        out_right_ascension;
  logic signed [31:0] out_declination;
  logic signed [31:0] out_mount_status;
  logic [15:0]        out_packet_length;
  logic [15:0]        out_packet_type;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;

  logic [7:0]       stream_bytes[$];
  lppd_pkg::rec_t   awaited_records[$];
  parse_state_t     rx_state;
  parse_state_t     gen_state;
  logic             byte_taken = 1'b0;
  int               send_idle_pct;
  int               pop_stall_pct;
  int               fail_count;
  int               bytes_accepted;
  int               records_checked;
  int               limit_settings;
  int               kind_count[4];

  length_prefixed_packet_deframer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_data_byte        (in_data_byte),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_kind            (out_kind),
    .out_server_time     (out_server_time),
    .out_right_ascension (out_right_ascension),
    .out_declination     (out_declination),
    .out_mount_status    (out_mount_status),
    .out_packet_length   (out_packet_length),
    .out_packet_type     (out_packet_type),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic parse_state_t reset_state();
    parse_state_t s;
    s = '0;
    s.limit = lppd_pkg::MAX_PACKET_BYTES_RESET;
    return s;
  endfunction

  function automatic bit deframe_byte(inout parse_state_t s, input logic [7:0] b,
                                      output lppd_pkg::rec_t r);
    bit done;
    r = '0;
    done = 1'b0;
    if (s.idx == lppd_pkg::IDX_LEN_LO) begin
      s.len = {8'h00, b};
      s.idx = lppd_pkg::IDX_LEN_HI;
    end else if (s.idx == lppd_pkg::IDX_LEN_HI) begin
      s.len[15:8] = b;
      if (s.len < lppd_pkg::MIN_PACKET_BYTES || s.len > s.limit) begin
        r.kind = lppd_pkg::KIND_BAD_SIZE;
        r.packet_length = s.len;
        s.idx = lppd_pkg::IDX_LEN_LO;
        done = 1'b1;
      end else begin
        s.idx = lppd_pkg::IDX_TYPE_LO;
      end
    end else begin
      if (s.idx == lppd_pkg::IDX_TYPE_LO) s.ptype = {8'h00, b};
      else if (s.idx == lppd_pkg::IDX_TYPE_HI) s.ptype[15:8] = b;
      else if (s.idx < lppd_pkg::IDX_TIME_END) s.tm = {b, s.tm[63:8]};
      else if (s.idx < lppd_pkg::IDX_RA_END) s.ra = {b, s.ra[31:8]};
      else if (s.idx < lppd_pkg::IDX_DEC_END) s.dec = {b, s.dec[31:8]};
      else if (s.idx < lppd_pkg::POSITION_PACKET_BYTES) s.st = {b, s.st[31:8]};
      if ({1'b0, s.idx} + 17'd1 >= {1'b0, s.len}) begin
        r.packet_length = s.len;
        r.packet_type = s.ptype;
        if (s.ptype != lppd_pkg::TYPE_POSITION) begin
          r.kind = lppd_pkg::KIND_UNKNOWN;
        end else if (s.len < lppd_pkg::POSITION_PACKET_BYTES) begin
          r.kind = lppd_pkg::KIND_TOO_SHORT;
        end else begin
          r.kind = lppd_pkg::KIND_POSITION;
          r.server_time = s.tm;
          r.right_ascension = s.ra;
          r.declination = s.dec;
          r.mount_status = s.st;
        end
        s.idx = lppd_pkg::IDX_LEN_LO;
        done = 1'b1;
      end else begin
        s.idx = s.idx + 16'd1;
      end
    end
    return done;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk) begin
    if (!in_push || byte_taken) begin
      if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push <= 1'b1;
        in_data_byte <= stream_bytes.pop_front();
      end else begin
        in_push <= 1'b0;
      end
    end
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin : monitor
    lppd_pkg::rec_t want;
    lppd_pkg::rec_t made;
    byte_taken <= in_push && !in_full;
    if (rst_n) begin
      if (cfg_wr_en) rx_state.limit = cfg_wr_data;
      if (in_push && !in_full) begin
        bytes_accepted++;
        if (deframe_byte(rx_state, in_data_byte, made)) awaited_records.push_back(made);
      end
      if (out_pop && !out_empty) begin
        if (awaited_records.size() == 0) begin
          $error("unexpected transaction: kind %0d length %0d", out_kind, out_packet_length);
          fail_count++;
        end else begin
          want = awaited_records.pop_front();
          compare_field("kind", {62'h0, want.kind}, {62'h0, out_kind});
          compare_field("server_time", want.server_time, out_server_time);
          compare_field("right_ascension", {32'h0, want.right_ascension},
                        {32'h0, out_right_ascension});
          compare_field("declination", {32'h0, want.declination}, {32'h0, out_declination});
          compare_field("mount_status", {32'h0, want.mount_status}, {32'h0, out_mount_status});
          compare_field("packet_length", {48'h0, want.packet_length},
                        {48'h0, out_packet_length});
          compare_field("packet_type", {48'h0, want.packet_type}, {48'h0, out_packet_type});
          records_checked++;
          kind_count[want.kind]++;
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    lppd_pkg::rec_t unused;
    stream_bytes.push_back(b);
    void'(deframe_byte(gen_state, b, unused));
  endtask

  task automatic queue_length(input logic [15:0] len);
    queue_byte(len[7:0]);
    queue_byte(len[15:8]);
  endtask

  task automatic queue_header(input logic [15:0] len, input logic [15:0] typ);
    queue_length(len);
    queue_byte(typ[7:0]);
    queue_byte(typ[15:8]);
  endtask

  task automatic queue_filler(input int count);
    repeat (count) queue_byte(8'($urandom_range(255)));
  endtask

  task automatic queue_position(input logic [15:0] len, input logic [63:0] tm,
                                input logic [31:0] ra, input logic [31:0] dec,
                                input logic [31:0] st);
    queue_header(len, lppd_pkg::TYPE_POSITION);
    for (int i = 0; i < 8; i++) queue_byte(tm[8*i +: 8]);
    for (int i = 0; i < 4; i++) queue_byte(ra[8*i +: 8]);
    for (int i = 0; i < 4; i++) queue_byte(dec[8*i +: 8]);
    for (int i = 0; i < 4; i++) queue_byte(st[8*i +: 8]);
    queue_filler(int'(len) - 24);
  endtask

  task automatic queue_random_packet();
    int pick;
    int hi;
    int len;
    pick = $urandom_range(99);
    hi = (gen_state.limit > 40) ? 40 : int'(gen_state.limit);
    if (pick < 40) begin
      queue_position(16'($urandom_range(hi, 24)), {$urandom, $urandom}, $urandom, $urandom,
                     $urandom);
    end else if (pick < 55) begin
      len = $urandom_range(23, 4);
      queue_header(16'(len), lppd_pkg::TYPE_POSITION);
      queue_filler(len - 4);
    end else if (pick < 75) begin
      len = $urandom_range(hi, 4);
      queue_header(16'(len), 16'($urandom_range(65535, 1)));
      queue_filler(len - 4);
    end else if (pick < 88 || gen_state.limit > 1000) begin
      if (gen_state.limit != 16'hFFFF && $urandom_range(1) == 1)
        queue_length(16'($urandom_range(65535, int'(gen_state.limit) + 1)));
      else
        queue_length(16'($urandom_range(3, 0)));
    end else begin
      queue_filler(int'($urandom_range(6, 1)));
      while (gen_state.idx != lppd_pkg::IDX_LEN_LO) queue_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic queue_random_stream(input int count);
    int target;
    target = stream_bytes.size() + count;
    while (stream_bytes.size() < target) queue_random_packet();
  endtask

  task automatic begin_phase(input bit write_limit, input logic [15:0] limit_val,
                             input int send_pct, input int stall_pct);
    if (write_limit) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= limit_val;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      gen_state.limit = limit_val;
      @(posedge clk);
    end
    limit_settings++;
    send_idle_pct = send_pct;
    pop_stall_pct = stall_pct;
  endtask

  task automatic drain_phase();
    while (stream_bytes.size() != 0 || in_push || awaited_records.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 16'h0000;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    fail_count = 0;
    bytes_accepted = 0;
    records_checked = 0;
    limit_settings = 0;
    kind_count = '{0, 0, 0, 0};
    rx_state = reset_state();
    gen_state = reset_state();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    begin_phase(1'b0, lppd_pkg::MAX_PACKET_BYTES_RESET, 0, 0);
    queue_length(16'd3);
    queue_length(16'd121);
    queue_length(16'hFFFF);
    queue_length(16'd0);
    queue_header(16'd4, 16'hFFFF);
    queue_header(16'd4, lppd_pkg::TYPE_POSITION);
    queue_position(16'd24, 64'h8000_0000_0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF);
    drain_phase();

    begin_phase(1'b1, 16'd24, 0, 0);
    queue_length(16'd25);
    queue_position(16'd24, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_random_stream(200);
    drain_phase();

    begin_phase(1'b1, 16'hFFFF, 0, 0);
    queue_position(16'd48, {$urandom, $urandom}, $urandom, $urandom, $urandom);
    queue_random_stream(150);
    drain_phase();

    begin_phase(1'b1, 16'd3, 0, 0);
    queue_length(16'd3);
    queue_length(16'd4);
    queue_length(16'd0);
    queue_filler(40);
    drain_phase();

    begin_phase(1'b1, 16'd200, 67, 0);
    queue_random_stream(300);
    drain_phase();

    begin_phase(1'b1, 16'd60, 0, 67);
    queue_random_stream(300);
    drain_phase();

    begin_phase(1'b1, 16'd1000, 9, 9);
    queue_random_stream(300);
    drain_phase();

    begin_phase(1'b1, lppd_pkg::MAX_PACKET_BYTES_RESET, 67, 67);
    queue_random_stream(250);
    drain_phase();

    $display("Streamed %0d bytes under %0d size limits and checked %0d records.",
             bytes_accepted, limit_settings, records_checked);
    $display("Records by kind: position %0d, bad size %0d, too short %0d, unknown %0d.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
sv/lppd_pkg.sv
sv/lppd_parser.sv
sv/lppd_queue.sv
sv/lppd_out_stage.sv
sv/length_prefixed_packet_deframer.sv
tb/sv/tb_top.sv
